// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL of the color converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define RGBHSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgbhsv assertion failed");

// The condition on the right must hold in the cycle after the one on the left.
`define RGBHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgbhsv assertion failed");

`endif

// File: rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types, constants and the divider step shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int C_CHAN_W     = 8;
    localparam int C_DIV_STAGES = 4;
    localparam int C_DIV_BITS   = C_CHAN_W / C_DIV_STAGES;

    localparam logic [C_CHAN_W-1:0] C_SAT_SCALE = 8'd255;
    localparam logic [C_CHAN_W-1:0] C_HUE_SCALE = 8'd43;
    localparam logic [C_CHAN_W-1:0] C_BASE_RED   = 8'd0;
    localparam logic [C_CHAN_W-1:0] C_BASE_GREEN = 8'd85;
    localparam logic [C_CHAN_W-1:0] C_BASE_BLUE  = 8'd171;

    typedef logic [C_CHAN_W-1:0] t_chan;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Partial state of a restoring division: running remainder, and a word
    // that holds the unused low numerator bits on the left and the quotient
    // bits found so far on the right.
    typedef struct packed {
        t_chan rem;
        t_chan quo;
    } t_div;

    function automatic t_div div_steps(input t_div s, input t_chan d);
        t_div                o;
        logic [C_CHAN_W:0]   t;
        logic                ge;
        o = s;
        for (int i = 0; i < C_DIV_BITS; i++) begin
            t     = {o.rem, o.quo[C_CHAN_W-1]};
            ge    = (t >= {1'b0, d});
            o.rem = ge ? C_CHAN_W'(t - {1'b0, d}) : t[C_CHAN_W-1:0];
            o.quo = {o.quo[C_CHAN_W-2:0], ge};
        end
        return o;
    endfunction

    function automatic t_chan sector_base(input t_sector s);
        t_chan b;
        unique case (s)
            SEC_RED:   b = C_BASE_RED;
            SEC_GREEN: b = C_BASE_GREEN;
            SEC_BLUE:  b = C_BASE_BLUE;
            default:   b = C_BASE_RED;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/rgbhsv_if.sv
// ----------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready channels for RGB pixels in and HSV pixels out.
// ----------------------------------------------------------------------------
interface rgbhsv_rgb_if;
    import rgbhsv_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
    import rgbhsv_pkg::*;

    logic  valid;
    logic  ready;
    t_chan hue;
    t_chan saturation;
    t_chan brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                     output ready);
endinterface

// File: rtl/rgb_to_hsv_8bit_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_top
// Throughput: one item per cycle while the output is not stalled.
// The pipeline holds up to 7 items.
// The two 8-stage restoring dividers are split over 4 pipeline stages.
// Reset (synchronous, active low) clears all valid bits; the pipeline is empty.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   stage 0  max, min, range, sector and the signed hue difference
//   stage 1  numerators 255*range and 43*|difference|
//   stage 2..5  two quotient bits of both divisions per stage
//   stage 6  output register: special cases and the hue sum modulo 256
//
// The whole pipeline advances together whenever the output register is empty
// or its item is being taken, so a stall freezes every stage and nothing is
// lost or repeated.
module rgb_to_hsv_8bit_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsv_rgb_if.sink    i_pix,
    rgbhsv_hsv_if.source  o_pix
);
    import rgbhsv_pkg::*;

    `include "assert_macros.svh"

    localparam int C_LAST = C_DIV_STAGES + 2;

    logic        w_adv;
    logic        r_vld [0:C_LAST];

    // Stage 0 combinational values.
    t_chan       w_mx;
    t_chan       w_mn;
    t_chan       w_x;
    t_chan       w_y;
    t_sector     w_sec;

    // Stage 0 registers.
    t_chan       r1_mx;
    t_chan       r1_delta;
    t_chan       r1_a;
    logic        r1_neg;
    t_sector     r1_sec;

    // Stage 1 numerators.
    logic [2*C_CHAN_W-1:0] w_nsat;
    logic [2*C_CHAN_W-1:0] w_nhue;

    // Division pipeline; entry 0 is loaded by stage 1.
    t_div        r_div_s [0:C_DIV_STAGES];
    t_div        r_div_h [0:C_DIV_STAGES];
    t_chan       r_dvh   [0:C_DIV_STAGES];
    t_chan       r_mx    [0:C_DIV_STAGES];
    logic        r_neg   [0:C_DIV_STAGES];
    t_sector     r_sec   [0:C_DIV_STAGES];

    // Output stage.
    t_chan       w_sat;
    t_chan       w_term;
    t_chan       w_hue;
    t_chan       r_hue;
    t_chan       r_sat;
    t_chan       r_bri;

    // The pipeline may move when the output register is free or emptying.
    assign w_adv       = !r_vld[C_LAST] || o_pix.ready;
    assign i_pix.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= C_LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_pix.valid;
            for (int k = 1; k <= C_LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 0: find the largest and smallest channel. Ties go to red first,
    // then green. The two remaining channels give the hue difference.
    always_comb begin
        w_mx = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        if (i_pix.blue > w_mx) begin
            w_mx = i_pix.blue;
        end
        w_mn = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        if (i_pix.blue < w_mn) begin
            w_mn = i_pix.blue;
        end
        priority if (w_mx == i_pix.red) begin
            w_sec = SEC_RED;
            w_x   = i_pix.green;
            w_y   = i_pix.blue;
        end else if (w_mx == i_pix.green) begin
            w_sec = SEC_GREEN;
            w_x   = i_pix.blue;
            w_y   = i_pix.red;
        end else begin
            w_sec = SEC_BLUE;
            w_x   = i_pix.red;
            w_y   = i_pix.green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mx    <= w_mx;
            r1_delta <= w_mx - w_mn;
            r1_a     <= (w_x >= w_y) ? (w_x - w_y) : (w_y - w_x);
            r1_neg   <= (w_x < w_y);
            r1_sec   <= w_sec;
        end
    end

    // Stage 1: numerators. Both quotients fit in eight bits because the
    // numerator is below 256 times the divisor, so the upper byte is already
    // a valid starting remainder.
    assign w_nsat = (2*C_CHAN_W)'(r1_delta) * (2*C_CHAN_W)'(C_SAT_SCALE);
    assign w_nhue = (2*C_CHAN_W)'(r1_a) * (2*C_CHAN_W)'(C_HUE_SCALE);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_div_s[0] <= '{rem: w_nsat[2*C_CHAN_W-1:C_CHAN_W], quo: w_nsat[C_CHAN_W-1:0]};
            r_div_h[0] <= '{rem: w_nhue[2*C_CHAN_W-1:C_CHAN_W], quo: w_nhue[C_CHAN_W-1:0]};
            r_dvh[0]   <= r1_delta;
            r_mx[0]    <= r1_mx;
            r_neg[0]   <= r1_neg;
            r_sec[0]   <= r1_sec;
        end
    end

    // Stages 2 to 5: saturation divides by the maximum, hue by the range.
    // A zero divisor gives a meaningless quotient that the output stage
    // replaces.
    for (genvar s = 0; s < C_DIV_STAGES; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_div_s[s+1] <= div_steps(r_div_s[s], r_mx[s]);
                r_div_h[s+1] <= div_steps(r_div_h[s], r_dvh[s]);
                r_dvh[s+1]   <= r_dvh[s];
                r_mx[s+1]    <= r_mx[s];
                r_neg[s+1]   <= r_neg[s];
                r_sec[s+1]   <= r_sec[s];
            end
        end
    end

    // Output stage: a black pixel has no saturation, and a grey pixel (zero
    // saturation) has no hue. Otherwise the signed term is added to the
    // sector offset and wraps modulo 256.
    always_comb begin
        w_sat  = (r_mx[C_DIV_STAGES] == '0) ? '0 : r_div_s[C_DIV_STAGES].quo;
        w_term = r_neg[C_DIV_STAGES] ? (t_chan'(0) - r_div_h[C_DIV_STAGES].quo)
                                     : r_div_h[C_DIV_STAGES].quo;
        w_hue  = (w_sat == '0) ? '0 : (sector_base(r_sec[C_DIV_STAGES]) + w_term);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue <= w_hue;
            r_sat <= w_sat;
            r_bri <= r_mx[C_DIV_STAGES];
        end
    end

    assign o_pix.valid      = r_vld[C_LAST];
    assign o_pix.hue        = r_hue;
    assign o_pix.saturation = r_sat;
    assign o_pix.brightness = r_bri;

    // A black result carries neither hue nor saturation.
    `RGBHSV_ASSERT_IMP(a_black, i_clk, i_rst_n, o_pix.valid && (o_pix.brightness == '0), (o_pix.hue == '0) && (o_pix.saturation == '0))
    // A grey result carries no hue.
    `RGBHSV_ASSERT_IMP(a_grey, i_clk, i_rst_n, o_pix.valid && (o_pix.saturation == '0), o_pix.hue == '0)
    // The hue quotient never exceeds the sector scale when the range is nonzero.
    `RGBHSV_ASSERT_IMP(a_hue_q, i_clk, i_rst_n, r_vld[C_LAST-1] && (r_dvh[C_DIV_STAGES] != '0), r_div_h[C_DIV_STAGES].quo <= C_HUE_SCALE)
    // An item in the first stage moves on whenever the pipeline advances.
    `RGBHSV_ASSERT_NEXT(a_advance, i_clk, i_rst_n, r_vld[0] && w_adv, r_vld[1])

endmodule
